@@ src/rle_hex_pixel_decoder_defines.svh @@
// Assertion macros used by the checker file.
`ifndef RLE_HEX_PIXEL_DECODER_DEFINES_SVH
`define RLE_HEX_PIXEL_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, idle while rst is high.
`define RHPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, idle while rst is high.
`define RHPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/rhpd_pkg.sv @@
`default_nettype none

package rhpd_pkg;

  localparam int CfgW   = 13;
  localparam int PosW   = 12;
  localparam int ChanW  = 2;
  localparam int RunW   = 5;
  localparam int MaxDim = 4096;

  localparam logic [CfgW-1:0] WidthReset  = 13'd640;
  localparam logic [CfgW-1:0] HeightReset = 13'd480;

  // parse phase codes
  localparam logic [1:0] PH_FIRST    = 2'd0;
  localparam logic [1:0] PH_PAIR_LOW = 2'd1;
  localparam logic [1:0] PH_RUN_HIGH = 2'd2;
  localparam logic [1:0] PH_RUN_LOW  = 2'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;   // input transfer this cycle
    logic emit_run;  // emit the next byte of a pending run
  } rhpd_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic in_run;    // the offered character closes a run header
    logic rem_last;  // one run byte left to emit
    logic out_free;  // output register can take a byte this cycle
  } rhpd_stat_t;

endpackage

`default_nettype wire

@@ src/rhpd_regs.sv @@
`default_nettype none

module rhpd_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [2:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output logic      [rhpd_pkg::CfgW-1:0]  image_width,
  output logic      [rhpd_pkg::CfgW-1:0]  image_height
);
  import rhpd_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WidthReset;
      image_height <= HeightReset;
    end else if (wr_en) begin
      if (paddr[2]) begin
        image_height <= pwdata[CfgW-1:0];
      end else begin
        image_width <= pwdata[CfgW-1:0];
      end
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2]) begin
      prdata[CfgW-1:0] = image_height;
    end else begin
      prdata[CfgW-1:0] = image_width;
    end
  end

endmodule

`default_nettype wire

@@ src/rhpd_ctrl.sv @@
`default_nettype none

module rhpd_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire rhpd_pkg::rhpd_stat_t  stat,
  output rhpd_pkg::rhpd_cmd_t        cmd
);
  import rhpd_pkg::*;

  localparam logic ST_ACCEPT = 1'b0;
  localparam logic ST_RUN    = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    cmd.load_in  = 1'b0;
    cmd.emit_run = 1'b0;
    case (state)
      ST_ACCEPT: begin
        s_tready    = stat.out_free;
        cmd.load_in = s_tvalid & stat.out_free;
        if (cmd.load_in && stat.in_run) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.emit_run = stat.out_free;
        if (stat.out_free && stat.rem_last) begin
          state_next = ST_ACCEPT;
        end
      end
      default: begin
        state_next = ST_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ src/rhpd_datapath.sv @@
`default_nettype none

module rhpd_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [rhpd_pkg::CfgW-1:0]  image_width,
  input  wire logic [rhpd_pkg::CfgW-1:0]  image_height,
  input  wire logic [7:0]                 char_code,
  input  wire logic                       frame_start,
  input  wire rhpd_pkg::rhpd_cmd_t        cmd,
  output rhpd_pkg::rhpd_stat_t            stat,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [7:0]                 byte_value,
  output logic      [rhpd_pkg::ChanW-1:0] channel,
  output logic      [rhpd_pkg::PosW-1:0]  column,
  output logic      [rhpd_pkg::PosW-1:0]  row,
  output logic                            out_of_range,
  output logic                            last_of_run
);
  import rhpd_pkg::*;

  logic [1:0]       phase;
  logic [1:0]       phase_eff;
  logic [7:0]       high_char;
  logic [RunW-1:0]  rem;
  logic [7:0]       run_value;
  logic [ChanW-1:0] chan_pos;
  logic [PosW-1:0]  col_pos;
  logic [PosW-1:0]  row_pos;

  logic [7:0]       nib_hi;
  logic [7:0]       nib_lo;
  logic [7:0]       pair_byte;
  logic [CfgW-1:0]  width_eff;
  logic [CfgW-1:0]  col_inc;
  logic             emit_in;
  logic             emit_any;
  logic [7:0]       emit_value;
  logic             emit_last;

  function automatic logic [7:0] nibble_of(input logic [7:0] ch);
    if (ch >= "A" && ch <= "F") begin
      nibble_of = ch - 8'("A") + 8'd10;
    end else begin
      nibble_of = ch - 8'("0");
    end
  endfunction

  always_comb begin
    phase_eff   = frame_start ? PH_FIRST : phase;
    nib_hi      = nibble_of(high_char);
    nib_lo      = nibble_of(char_code);
    pair_byte   = {nib_hi[3:0] | nib_lo[7:4], nib_lo[3:0]};

    stat.in_run   = (phase_eff == PH_RUN_LOW);
    stat.rem_last = (rem == RunW'(1));
    stat.out_free = ~out_valid | out_ready;

    emit_in  = cmd.load_in &
               ((phase_eff == PH_PAIR_LOW) || (phase_eff == PH_RUN_LOW));
    emit_any = emit_in | cmd.emit_run;

    // run bytes after the first come from the held value
    emit_value = cmd.emit_run ? run_value : pair_byte;
    emit_last  = cmd.emit_run ? stat.rem_last : (phase_eff == PH_PAIR_LOW);

    // clamp width into 1..MaxDim
    if (image_width == '0) begin
      width_eff = CfgW'(1);
    end else if (image_width > CfgW'(MaxDim)) begin
      width_eff = CfgW'(MaxDim);
    end else begin
      width_eff = image_width;
    end
    col_inc = {1'b0, col_pos} + CfgW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_FIRST;
      rem       <= '0;
      chan_pos  <= '0;
      col_pos   <= '0;
      row_pos   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit_any) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cmd.load_in) begin
        case (phase_eff)
          PH_FIRST: begin
            if (char_code >= "a" && char_code <= "z") begin
              rem   <= RunW'(char_code - 8'("a") + 8'd2);
              phase <= PH_RUN_HIGH;
            end else begin
              phase <= PH_PAIR_LOW;
            end
          end
          PH_PAIR_LOW: phase <= PH_FIRST;
          PH_RUN_HIGH: phase <= PH_RUN_LOW;
          PH_RUN_LOW: begin
            rem   <= rem - RunW'(1);
            phase <= PH_FIRST;
          end
          default: phase <= PH_FIRST;
        endcase
      end else if (cmd.emit_run) begin
        rem <= rem - RunW'(1);
      end

      if (cmd.load_in && frame_start) begin
        chan_pos <= '0;
        col_pos  <= '0;
        row_pos  <= '0;
      end else if (emit_any) begin
        if (chan_pos == ChanW'(2)) begin
          chan_pos <= '0;
          if (col_inc >= width_eff) begin
            col_pos <= '0;
            if (row_pos != {PosW{1'b1}}) begin
              row_pos <= row_pos + PosW'(1);
            end
          end else begin
            col_pos <= col_inc[PosW-1:0];
          end
        end else begin
          chan_pos <= chan_pos + ChanW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in && (phase_eff == PH_FIRST || phase_eff == PH_RUN_HIGH)) begin
      high_char <= char_code;
    end
    if (emit_in) begin
      run_value <= pair_byte;
    end
    if (emit_any) begin
      byte_value   <= emit_value;
      channel      <= chan_pos;
      column       <= col_pos;
      row          <= row_pos;
      out_of_range <= ({1'b0, row_pos} >= image_height);
      last_of_run  <= emit_last;
    end
  end

endmodule

`default_nettype wire

@@ src/rle_hex_pixel_decoder.sv @@
// A byte appears on the output in the cycle after the transfer that causes it.
// Throughput: one character per cycle while s_tready is high; a pair gives one byte,
// a run letter plus pair gives 2..27 bytes at one per cycle, input held as it drains.
// One output register paces any source: one byte per cycle while m_tready is high.
// Reset (rst, synchronous): clears parse phase, position and output valid;
// image_width returns to 640 and image_height to 480.
`default_nettype none

module rle_hex_pixel_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // character stream in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_code
  input  wire logic [0:0]  s_tuser,   // [0] frame_start
  // colour bytes out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,   // [7:0] byte_value, [9:8] channel,
                                      // [21:10] column, [33:22] row, [39:34] zero
  output logic             m_tlast,   // last_of_run
  output logic      [0:0]  m_tuser    // [0] out_of_range
);
  import rhpd_pkg::*;

  logic [CfgW-1:0]  image_width;
  logic [CfgW-1:0]  image_height;
  rhpd_cmd_t        cmd;
  rhpd_stat_t       stat;
  logic [7:0]       byte_value;
  logic [ChanW-1:0] channel;
  logic [PosW-1:0]  column;
  logic [PosW-1:0]  row;
  logic             out_of_range;

  // Register file: width at byte address 0, height at byte address 4.
  rhpd_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .image_width  (image_width),
    .image_height (image_height)
  );

  // Controller: take characters, or hold input while a run drains.
  rhpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: parse state, pixel position and the output register.
  rhpd_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .char_code    (s_tdata),
    .frame_start  (s_tuser[0]),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .byte_value   (byte_value),
    .channel      (channel),
    .column       (column),
    .row          (row),
    .out_of_range (out_of_range),
    .last_of_run  (m_tlast)
  );

  // Pack the result fields, lowest field first, padded to whole bytes.
  assign m_tdata    = {6'd0, row, column, channel, byte_value};
  assign m_tuser[0] = out_of_range;

endmodule

`default_nettype wire

@@ src/rhpd_checker.sv @@
`default_nettype none
`include "rle_hex_pixel_decoder_defines.svh"

module rhpd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic        m_tlast,
  input wire logic [31:0] prdata
);

  // a stalled byte holds its payload
  `RHPD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output changed under stall")
  // channel only counts 0..2
  `RHPD_ASSERT_NOW(a_chan_range, m_tvalid, m_tdata[9:8] != 2'd3, "channel out of range")
  // a run in progress holds the input side
  `RHPD_ASSERT_NOW(a_run_blocks, m_tvalid && !m_tlast, !s_tready, "input taken during a run")
  // registers are 13 bits wide
  `RHPD_ASSERT_NOW(a_prdata_pad, 1'b1, prdata[31:13] == 19'd0, "read data upper bits set")

endmodule

bind rle_hex_pixel_decoder rhpd_checker u_chk (.*);

`default_nettype wire
